[rtl/mcpmq_pkg.sv]
// Shared types and constants for the multi-channel priority message queue.
`default_nettype none
package mcpmq_pkg;

  localparam int WORD_W = 32;
  localparam int MSG_W  = 4 * WORD_W;
  localparam int ACT_W  = 2;
  localparam int CHN_W  = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_POST  = 2'd0,
    ACT_GET   = 2'd1,
    ACT_FLUSH = 2'd2
  } action_t;

  typedef logic [MSG_W-1:0] msg_t;

endpackage
`default_nettype wire

[rtl/mcpmq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mcpmq_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/multi_channel_priority_msg_queue.sv]
// Top level of the multi-channel strict-priority message queue.
//
// Holds CHANNELS circular FIFOs of FIFO_DEPTH four-word messages, all kept in
// one synchronous RAM of CHANNELS*FIFO_DEPTH 128-bit entries; read/write
// pointers and fill counts per channel sit in flops. A post (action 0) writes
// the message at the channel's tail unless the channel is full or out of
// range, and reports accepted. A get (action 1) removes the oldest message of
// the lowest-numbered non-empty channel and returns it with found=1 and its
// channel; found=0 with zero data when all channels are empty. A flush
// (action 2) empties one channel. Every item gives exactly one result, written
// straight to the output register except for a get that finds a message,
// which first passes through the RAM's registered read data. The next item is
// taken as soon as the output register is free or being drained, and no item
// is taken while a RAM read is outstanding. No initialization pass is needed.
`default_nettype none
module multi_channel_priority_msg_queue #(
  parameter int CHANNELS   = 8,
  parameter int FIFO_DEPTH = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mcpmq_pkg::ACT_W-1:0]     in_action,
  input  wire logic [mcpmq_pkg::CHN_W-1:0]     in_channel,
  input  wire logic [mcpmq_pkg::WORD_W-1:0]    in_msg_code,
  input  wire logic [mcpmq_pkg::WORD_W-1:0]    in_word_param,
  input  wire logic [mcpmq_pkg::WORD_W-1:0]    in_long_param,
  input  wire logic [mcpmq_pkg::WORD_W-1:0]    in_extra_param,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_accepted,
  output logic                                 out_found,
  output logic      [mcpmq_pkg::CHN_W-1:0]     out_channel,
  output logic      [mcpmq_pkg::WORD_W-1:0]    out_code,
  output logic      [mcpmq_pkg::WORD_W-1:0]    out_word,
  output logic      [mcpmq_pkg::WORD_W-1:0]    out_long,
  output logic      [mcpmq_pkg::WORD_W-1:0]    out_extra
);

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int RAM_D  = CHANNELS * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);
  localparam int WW     = mcpmq_pkg::WORD_W;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [ADDR_W-1:0] CH_STEP  = ADDR_W'(FIFO_DEPTH);

  // per-channel pointers and counts
  logic [PTR_W-1:0] rd_ptr_r [CHANNELS];
  logic [PTR_W-1:0] wr_ptr_r [CHANNELS];
  logic [CNT_W-1:0] cnt_r    [CHANNELS];

  logic             rd_pend_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             accepted_r;
  logic             found_r;
  logic [mcpmq_pkg::CHN_W-1:0] ochan_r;
  mcpmq_pkg::msg_t  data_r;

  logic             acc;
  logic             ch_ok;
  logic [CH_W-1:0]  ch_idx;
  logic             post_ok;
  logic             get_hit;
  logic             flush_ok;
  logic             any_ne;
  logic [CH_W-1:0]  pick;
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W-1:0] wptr_nxt;
  logic [PTR_W-1:0] rptr_nxt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  mcpmq_pkg::msg_t  wr_msg;
  mcpmq_pkg::msg_t  rd_msg;

  assign in_ready = !rd_pend_r && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  assign ch_ok  = ({29'd0, in_channel} < CHANNELS);
  assign ch_idx = CH_W'(in_channel);

  // lowest-numbered non-empty channel wins
  always_comb begin
    any_ne = 1'b0;
    pick   = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (cnt_r[c] != '0) begin
        any_ne = 1'b1;
        pick   = CH_W'(c);
      end
    end
  end

  always_comb begin
    post_ok  = 1'b0;
    get_hit  = 1'b0;
    flush_ok = 1'b0;
    if (acc) begin
      unique case (mcpmq_pkg::action_t'(in_action))
        mcpmq_pkg::ACT_POST:  post_ok  = ch_ok && (cnt_r[ch_idx] != CNT_FULL);
        mcpmq_pkg::ACT_GET:   get_hit  = any_ne;
        mcpmq_pkg::ACT_FLUSH: flush_ok = ch_ok;
        default: ;
      endcase
    end
  end

  assign wptr     = ch_ok ? wr_ptr_r[ch_idx] : '0;
  assign rptr     = rd_ptr_r[pick];
  assign wptr_nxt = (wptr == PTR_LAST) ? '0 : wptr + PTR_W'(1);
  assign rptr_nxt = (rptr == PTR_LAST) ? '0 : rptr + PTR_W'(1);

  assign wr_addr = ADDR_W'(ch_idx) * CH_STEP + ADDR_W'(wptr);
  assign rd_addr = ADDR_W'(pick) * CH_STEP + ADDR_W'(rptr);
  assign wr_msg  = {in_msg_code, in_word_param, in_long_param, in_extra_param};

  mcpmq_ram #(
    .WIDTH (mcpmq_pkg::MSG_W),
    .DEPTH (RAM_D)
  ) u_store (
    .clk     (clk),
    .wr_en   (post_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_msg),
    .rd_en   (get_hit),
    .rd_addr (rd_addr),
    .rd_data (rd_msg)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (acc) begin
      // a get that hits shows its result once the RAM read returns
      out_valid_nxt = !get_hit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rd_ptr_r[c] <= '0;
        wr_ptr_r[c] <= '0;
        cnt_r[c]    <= '0;
      end
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= get_hit;
      out_valid_r <= out_valid_nxt;
      if (post_ok) begin
        wr_ptr_r[ch_idx] <= wptr_nxt;
        cnt_r[ch_idx]    <= cnt_r[ch_idx] + CNT_W'(1);
      end
      if (get_hit) begin
        rd_ptr_r[pick] <= rptr_nxt;
        cnt_r[pick]    <= cnt_r[pick] - CNT_W'(1);
      end
      if (flush_ok) begin
        rd_ptr_r[ch_idx] <= '0;
        wr_ptr_r[ch_idx] <= '0;
        cnt_r[ch_idx]    <= '0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      accepted_r <= post_ok;
      found_r    <= get_hit;
      ochan_r    <= get_hit ? mcpmq_pkg::CHN_W'(pick) : '0;
      data_r     <= '0;
    end else if (rd_pend_r) begin
      data_r <= rd_msg;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = accepted_r;
  assign out_found    = found_r;
  assign out_channel  = ochan_r;
  assign out_code     = data_r[4*WW-1:3*WW];
  assign out_word     = data_r[3*WW-1:2*WW];
  assign out_long     = data_r[2*WW-1:WW];
  assign out_extra    = data_r[WW-1:0];

endmodule
`default_nettype wire
